// ===== design/fhlp_pkg.sv =====
// ----------------------------------------------------------------------------
// fhlp_pkg
// Shared types, constants and register codes for the fixed header length
// parser: configuration layout, request and response words.
// ----------------------------------------------------------------------------
package fhlp_pkg;

	localparam int MAX_SIZE_BYTES_DEF = 8;
	localparam int MAX_SEQ_BYTES_DEF  = 4;

	localparam int BYTE_W      = 8;
	localparam int POS_W       = 10;
	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 16;

	// Request codes carried in req_type.
	localparam logic REQ_BYTE    = 1'b0;
	localparam logic REQ_RESTART = 1'b1;

	// Register indexes of the configuration port.
	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_PREFIX_BYTES = 3'd0,
		CFG_SIZE_BYTES   = 3'd1,
		CFG_SUFFIX_BYTES = 3'd2,
		CFG_BIG_ENDIAN   = 3'd3,
		CFG_SEQ_OFFSET   = 3'd4,
		CFG_SEQ_LENGTH   = 3'd5
	} cfg_index_t;

	typedef struct packed {
		logic [7:0] prefix_bytes;
		logic [3:0] size_bytes;
		logic [7:0] suffix_bytes;
		logic       big_endian;
		logic [9:0] seq_offset;
		logic [2:0] seq_length;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		prefix_bytes: 8'd0,
		size_bytes:   4'd4,
		suffix_bytes: 8'd0,
		big_endian:   1'b1,
		seq_offset:   10'd0,
		seq_length:   3'd0
	};

	typedef struct packed {
		logic       req_type;
		logic [7:0] data_byte;
	} req_t;

	typedef struct packed {
		logic [63:0] block_size;
		logic [31:0] seq_number;
		logic        seq_valid;
	} rsp_t;

endpackage

// ===== design/fhlp_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// fhlp_cfg_regs
// Configuration register file; each write lands in the register that its
// index selects, and writes to unused indexes are dropped.
// ----------------------------------------------------------------------------
module fhlp_cfg_regs (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [fhlp_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [fhlp_pkg::CFG_DATA_W-1:0]   cfg_data,
	output fhlp_pkg::cfg_t                    cfg
);

	fhlp_pkg::cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= fhlp_pkg::CFG_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				fhlp_pkg::CFG_PREFIX_BYTES: begin
					cfg_q.prefix_bytes <= cfg_data[7:0];
				end
				fhlp_pkg::CFG_SIZE_BYTES: begin
					cfg_q.size_bytes <= cfg_data[3:0];
				end
				fhlp_pkg::CFG_SUFFIX_BYTES: begin
					cfg_q.suffix_bytes <= cfg_data[7:0];
				end
				fhlp_pkg::CFG_BIG_ENDIAN: begin
					cfg_q.big_endian <= cfg_data[0];
				end
				fhlp_pkg::CFG_SEQ_OFFSET: begin
					cfg_q.seq_offset <= cfg_data[9:0];
				end
				fhlp_pkg::CFG_SEQ_LENGTH: begin
					cfg_q.seq_length <= cfg_data[2:0];
				end
				default: begin
				end
			endcase
		end
	end

endmodule

// ===== design/fhlp_parse_core.sv =====
// ----------------------------------------------------------------------------
// fhlp_parse_core
// Header position counter and field accumulators. Works out, for one byte,
// the updated size and sequence values and whether the header ends here.
// ----------------------------------------------------------------------------
module fhlp_parse_core #(
	parameter int MAX_SIZE_BYTES = fhlp_pkg::MAX_SIZE_BYTES_DEF,
	parameter int MAX_SEQ_BYTES  = fhlp_pkg::MAX_SEQ_BYTES_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  fhlp_pkg::cfg_t cfg,
	input  logic           fire,
	input  fhlp_pkg::req_t item,
	output logic           last,
	output fhlp_pkg::rsp_t result
);

	localparam int SIZE_W = fhlp_pkg::BYTE_W * MAX_SIZE_BYTES;
	localparam int SEQ_W  = fhlp_pkg::BYTE_W * MAX_SEQ_BYTES;
	localparam int POS_W  = fhlp_pkg::POS_W;
	localparam logic [3:0] SIZE_MAX = 4'(MAX_SIZE_BYTES);
	localparam logic [2:0] SEQ_MAX  = 3'(MAX_SEQ_BYTES);

	logic [POS_W-1:0]  pos_q;
	logic [SIZE_W-1:0] size_acc_q;
	logic [SEQ_W-1:0]  seq_acc_q;

	logic [3:0]        sb;
	logic [2:0]        sl;
	logic [POS_W-1:0]  size_end;
	logic [POS_W-1:0]  total;
	logic [POS_W:0]    seq_end;
	logic [POS_W-1:0]  size_off;
	logic [POS_W-1:0]  seq_off;
	logic              in_size;
	logic              in_seq;
	logic              seq_ok;
	logic [POS_W-1:0]  pos_inc;
	logic [SIZE_W-1:0] size_byte;
	logic [SEQ_W-1:0]  seq_byte;
	logic [SIZE_W-1:0] size_acc_nx;
	logic [SEQ_W-1:0]  seq_acc_nx;

	always_comb begin
		// Out-of-range widths are clamped to the supported span.
		if (cfg.size_bytes == 4'd0) begin
			sb = 4'd1;
		end else if (cfg.size_bytes > SIZE_MAX) begin
			sb = SIZE_MAX;
		end else begin
			sb = cfg.size_bytes;
		end
		sl = (cfg.seq_length > SEQ_MAX) ? SEQ_MAX : cfg.seq_length;

		size_end = POS_W'(cfg.prefix_bytes) + POS_W'(sb);
		total    = size_end + POS_W'(cfg.suffix_bytes);
		seq_end  = (POS_W+1)'(cfg.seq_offset) + (POS_W+1)'(sl);

		in_size  = (pos_q >= POS_W'(cfg.prefix_bytes)) && (pos_q < size_end);
		in_seq   = (pos_q >= cfg.seq_offset) && ((POS_W+1)'(pos_q) < seq_end);
		size_off = pos_q - POS_W'(cfg.prefix_bytes);
		seq_off  = pos_q - cfg.seq_offset;

		size_byte = SIZE_W'(item.data_byte);
		seq_byte  = SEQ_W'(item.data_byte);

		size_acc_nx = size_acc_q;
		if (in_size) begin
			if (cfg.big_endian) begin
				size_acc_nx = (size_acc_q << 8) | size_byte;
			end else begin
				size_acc_nx = size_acc_q | (size_byte << {size_off[2:0], 3'b000});
			end
		end

		seq_acc_nx = seq_acc_q;
		if (in_seq) begin
			if (cfg.big_endian) begin
				seq_acc_nx = (seq_acc_q << 8) | seq_byte;
			end else begin
				seq_acc_nx = seq_acc_q | (seq_byte << {seq_off[1:0], 3'b000});
			end
		end

		pos_inc = pos_q + POS_W'(1);
		last    = (item.req_type == fhlp_pkg::REQ_BYTE) && (pos_inc >= total);
		seq_ok  = seq_end <= (POS_W+1)'(total);

		result.block_size = 64'(size_acc_nx);
		result.seq_number = seq_ok ? 32'(seq_acc_nx) : 32'd0;
		result.seq_valid  = seq_ok;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q      <= '0;
			size_acc_q <= '0;
			seq_acc_q  <= '0;
		end else if (fire) begin
			if (item.req_type == fhlp_pkg::REQ_RESTART || last) begin
				pos_q      <= '0;
				size_acc_q <= '0;
				seq_acc_q  <= '0;
			end else begin
				pos_q      <= pos_inc;
				size_acc_q <= size_acc_nx;
				seq_acc_q  <= seq_acc_nx;
			end
		end
	end

	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		fire && last |=> pos_q == '0 && size_acc_q == '0 && seq_acc_q == '0)
		else $error("header end did not clear the parse state");

	a_restart_clears: assert property (@(posedge clk) disable iff (!arst_n)
		fire && item.req_type == fhlp_pkg::REQ_RESTART |=> pos_q == '0 && size_acc_q == '0)
		else $error("restart did not clear the parse state");

endmodule

// ===== design/fhlp_out_reg.sv =====
// ----------------------------------------------------------------------------
// fhlp_out_reg
// Result register on the response channel; holds a word until the receiver
// takes it and reports when a new word may be loaded.
// ----------------------------------------------------------------------------
module fhlp_out_reg (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           load,
	input  fhlp_pkg::rsp_t data,
	output logic           free,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output fhlp_pkg::rsp_t rsp
);

	logic           valid_q;
	fhlp_pkg::rsp_t data_q;

	assign free      = !valid_q || !rsp_stall;
	assign rsp_valid = valid_q;
	assign rsp       = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= data;
		end
	end

endmodule

// ===== design/fixed_header_length_parser_unit.sv =====
// The last header byte is held in the input register and its result word is then loaded into
// the result register that drives rsp. Throughput: one request word per cycle while req_stall
// is low; the position compare and accumulator update fit in the single stage between them.
// The input stage stalls only while it holds a header-ending byte and the result register
// holds a word that rsp_stall keeps from leaving.
// Reset (arst_n, asynchronous, active low) empties both registers, clears the position and
// accumulators, and loads the configuration defaults; no clearing pass is needed.
// ----------------------------------------------------------------------------
// fixed_header_length_parser_unit
// Deframer for fixed-length headers carrying a length prefix: skips the
// prefix, gathers the block size, skips the suffix and reports the size and
// an optional sequence number once per header.
// ----------------------------------------------------------------------------
module fixed_header_length_parser_unit #(
	parameter int MAX_SIZE_BYTES = fhlp_pkg::MAX_SIZE_BYTES_DEF,
	parameter int MAX_SEQ_BYTES  = fhlp_pkg::MAX_SEQ_BYTES_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// Request channel: one header byte or a restart per word.
	input  logic                             req_valid,
	output logic                             req_stall,
	input  fhlp_pkg::req_t                   req,
	// Response channel: one word per completed header.
	output logic                             rsp_valid,
	input  logic                             rsp_stall,
	output fhlp_pkg::rsp_t                   rsp,
	// Configuration write channel.
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [fhlp_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [fhlp_pkg::CFG_DATA_W-1:0]  cfg_data
);

	fhlp_pkg::cfg_t cfg;
	fhlp_pkg::req_t item_s1;
	fhlp_pkg::rsp_t result;
	logic           valid_s1;
	logic           last;
	logic           out_free;
	logic           adv;

	// The configuration is to be only rewritten by the user while the block is
	// idle, so the parse stage may read the registers directly; the block does not enforce it.
	fhlp_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// The word in the input register moves on when it ends no header, or
	// when the result register can take the word it produces. A byte that
	// does not finish a header never waits on the response side.
	assign adv       = valid_s1 && (!last || out_free);
	assign req_stall = valid_s1 && !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_valid && !req_stall) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && !req_stall) begin
			item_s1 <= req;
		end
	end

	fhlp_parse_core #(
		.MAX_SIZE_BYTES (MAX_SIZE_BYTES),
		.MAX_SEQ_BYTES  (MAX_SEQ_BYTES)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.fire   (adv),
		.item   (item_s1),
		.last   (last),
		.result (result)
	);

	fhlp_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (adv && last),
		.data      (result),
		.free      (out_free),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	// A stall is only raised while the input register holds a word.
	a_stall_needs_word: assert property (@(posedge clk) disable iff (!arst_n)
		req_stall |-> valid_s1)
		else $error("request stalled with an empty input register");

	// A held word must survive unchanged until it can be processed.
	a_held_word_kept: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv |=> valid_s1 && $stable(item_s1))
		else $error("held request word was lost or altered");

	// A header end facing a full, stalled result register must back-pressure.
	a_full_output_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && last && rsp_valid && rsp_stall |-> req_stall)
		else $error("result would overwrite a waiting response word");

endmodule

// ===== test/tb_fixed_header_length_parser_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_fixed_header_length_parser_unit
// Self-checking bench for the length-prefix header deframer. Header byte
// words and restarts are driven in random bursts. The receiver stalls in
// shifting patterns. A scoreboard class keeps its own copy of the register
// file and the parse state, and predicts each result word at the moment the
// input word is accepted. Directed headers cover the field extremes and the
// corner cases. Random configuration phases follow, each with well-formed
// headers, truncated headers and stray restarts.
// ----------------------------------------------------------------------------
module tb_fixed_header_length_parser_unit;

	localparam int ITEM_TARGET = 1950;
	localparam int QUIET_LIMIT = 2000;
	localparam int SETTLE_CYCLES = 6;

	// Scoreboard: mirrors the registers and the header state, holds the result
	// words still due and compares each delivered word with the oldest of them.
	class deframer_scoreboard;
		fhlp_pkg::cfg_t             regs;
		logic [fhlp_pkg::POS_W-1:0] hdr_pos;
		logic [63:0]                size_acc;
		logic [31:0]                seq_acc;
		fhlp_pkg::rsp_t             due_results[$];
		int unsigned                errors;

		function new();
			regs = fhlp_pkg::CFG_RESET;
			errors = 0;
			clear_header();
		endfunction

		function void clear_header();
			hdr_pos = '0;
			size_acc = '0;
			seq_acc = '0;
		endfunction

		// A size width of zero behaves as one byte, anything wider than the
		// maximum as the maximum.
		function int unsigned size_width();
			if (regs.size_bytes == 0)
				return 1;
			if (regs.size_bytes > fhlp_pkg::MAX_SIZE_BYTES_DEF)
				return fhlp_pkg::MAX_SIZE_BYTES_DEF;
			return regs.size_bytes;
		endfunction

		function int unsigned seq_width();
			if (regs.seq_length > fhlp_pkg::MAX_SEQ_BYTES_DEF)
				return fhlp_pkg::MAX_SEQ_BYTES_DEF;
			return regs.seq_length;
		endfunction

		function int unsigned header_length();
			return regs.prefix_bytes + size_width() + regs.suffix_bytes;
		endfunction

		function void write_reg(logic [fhlp_pkg::CFG_INDEX_W-1:0] idx,
				logic [fhlp_pkg::CFG_DATA_W-1:0] d);
			case (idx)
				fhlp_pkg::CFG_PREFIX_BYTES: regs.prefix_bytes = d[7:0];
				fhlp_pkg::CFG_SIZE_BYTES:   regs.size_bytes = d[3:0];
				fhlp_pkg::CFG_SUFFIX_BYTES: regs.suffix_bytes = d[7:0];
				fhlp_pkg::CFG_BIG_ENDIAN:   regs.big_endian = d[0];
				fhlp_pkg::CFG_SEQ_OFFSET:   regs.seq_offset = d[9:0];
				fhlp_pkg::CFG_SEQ_LENGTH:   regs.seq_length = d[2:0];
				default: ;
			endcase
		endfunction

		function void note_word(fhlp_pkg::req_t w);
			int unsigned    sz_n;
			int unsigned    sq_n;
			int unsigned    total;
			int unsigned    p;
			bit             seq_ok;
			fhlp_pkg::rsp_t r;
			if (w.req_type == fhlp_pkg::REQ_RESTART) begin
				clear_header();
				return;
			end
			sz_n = size_width();
			sq_n = seq_width();
			total = header_length();
			p = hdr_pos;
			if (p >= regs.prefix_bytes && p < regs.prefix_bytes + sz_n) begin
				if (regs.big_endian)
					size_acc = {size_acc[55:0], w.data_byte};
				else
					size_acc = size_acc |
						(64'(w.data_byte) << (8 * (p - regs.prefix_bytes)));
			end
			if (p >= regs.seq_offset && p < regs.seq_offset + sq_n) begin
				if (regs.big_endian)
					seq_acc = {seq_acc[23:0], w.data_byte};
				else
					seq_acc = seq_acc |
						(32'(w.data_byte) << (8 * (p - regs.seq_offset)));
			end
			hdr_pos = fhlp_pkg::POS_W'(p + 1);
			// The header closes on the first byte that takes the position to the
			// current length, even if the registers changed part way through.
			if (hdr_pos < total)
				return;
			seq_ok = (regs.seq_offset + sq_n) <= total;
			r.block_size = size_acc;
			r.seq_number = seq_ok ? seq_acc : '0;
			r.seq_valid = seq_ok;
			due_results.push_back(r);
			clear_header();
		endfunction

		function void note_error(string what, logic [63:0] exp_v, logic [63:0] got_v);
			errors++;
			if (errors <= 10)
				$display("%0t: %s mismatch: expected %h, got %h", $realtime, what,
					exp_v, got_v);
		endfunction

		function void check_word(fhlp_pkg::rsp_t got);
			fhlp_pkg::rsp_t exp_r;
			if (due_results.size() == 0) begin
				note_error("unexpected result word, block_size", '0, got.block_size);
				return;
			end
			exp_r = due_results.pop_front();
			if (got.block_size !== exp_r.block_size)
				note_error("block_size", exp_r.block_size, got.block_size);
			if (got.seq_number !== exp_r.seq_number)
				note_error("seq_number", exp_r.seq_number, got.seq_number);
			if (got.seq_valid !== exp_r.seq_valid)
				note_error("seq_valid", exp_r.seq_valid, got.seq_valid);
		endfunction
	endclass

	// Every input starts at a known value.
	logic                             clk = 1'b0;
	logic                             arst_n = 1'b0;
	logic                             req_valid = 1'b0;
	logic                             req_stall;
	fhlp_pkg::req_t                   req = '0;
	logic                             rsp_valid;
	logic                             rsp_stall = 1'b0;
	fhlp_pkg::rsp_t                   rsp;
	logic                             cfg_valid = 1'b0;
	logic                             cfg_ready;
	logic [fhlp_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
	logic [fhlp_pkg::CFG_DATA_W-1:0]  cfg_data = '0;

	deframer_scoreboard sb = new();

	int unsigned items_sent = 0;
	int unsigned burst_left = 0;
	int unsigned quiet = 0;
	int unsigned stall_mode = 0;
	int unsigned stall_age = 0;
	logic [3:0]  stall_tick = '0;

	fixed_header_length_parser_unit uut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	// Receiver: every accepted result word goes to the scoreboard. The stall
	// pattern switches now and then between no stalls, light random stalls,
	// heavy random stalls and a regular on/off rhythm.
	always @(posedge clk) begin
		if (rsp_valid && !rsp_stall)
			sb.check_word(rsp);
		stall_tick <= stall_tick + 1'b1;
		if (stall_age == 0) begin
			stall_mode <= $urandom_range(0, 3);
			stall_age <= $urandom_range(16, 96);
		end else begin
			stall_age <= stall_age - 1;
		end
		case (stall_mode)
			0: rsp_stall <= 1'b0;
			1: rsp_stall <= ($urandom_range(0, 3) == 0);
			2: rsp_stall <= ($urandom_range(0, 3) != 0);
			default: rsp_stall <= stall_tick[1];
		endcase
	end

	// Watchdog: a long stretch with no word moving on any channel means the
	// block has hung or a result word has gone missing.
	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
				(cfg_valid && cfg_ready)) begin
			quiet <= 0;
		end else if (quiet >= QUIET_LIMIT) begin
			$display("fixed_header_length_parser_unit test failed");
			$finish;
		end else begin
			quiet <= quiet + 1;
		end
	end

	// Sends one request word. Words go out in bursts of random length; between
	// bursts the valid may drop, though often it does not, so that long
	// unbroken stretches occur as well.
	task automatic send_word(input fhlp_pkg::req_t w);
		int unsigned gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				req_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		req_valid <= 1'b1;
		req <= w;
		do @(posedge clk); while (req_stall);
		sb.note_word(w);
		items_sent++;
	endtask

	task automatic send_byte(input logic [7:0] b);
		send_word('{req_type: fhlp_pkg::REQ_BYTE, data_byte: b});
	endtask

	task automatic send_restart();
		send_word('{req_type: fhlp_pkg::REQ_RESTART, data_byte: 8'($urandom)});
	endtask

	// Random header content, leaning on all-zero and all-one bytes now and then.
	function automatic logic [7:0] random_byte();
		case ($urandom_range(0, 7))
			0: return 8'h00;
			1: return 8'hFF;
			default: return 8'($urandom);
		endcase
	endfunction

	task automatic send_random_bytes(input int unsigned n);
		repeat (n) send_byte(random_byte());
	endtask

	task automatic stop_sending();
		req_valid <= 1'b0;
		burst_left = 0;
	endtask

	// Idle means every predicted word has arrived, plus a settling wait for bytes
	// still in the pipeline that close no header.
	task automatic wait_idle();
		while (sb.due_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [fhlp_pkg::CFG_INDEX_W-1:0] idx,
			input logic [fhlp_pkg::CFG_DATA_W-1:0] d);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		do @(posedge clk); while (!cfg_ready);
		sb.write_reg(idx, d);
	endtask

	// Writes the whole register file with random junk above each field, and
	// sometimes an unused index as well, which must change nothing.
	task automatic apply_config(input fhlp_pkg::cfg_t c);
		stop_sending();
		wait_idle();
		write_reg(fhlp_pkg::CFG_PREFIX_BYTES, {8'($urandom), c.prefix_bytes});
		write_reg(fhlp_pkg::CFG_SIZE_BYTES, {12'($urandom), c.size_bytes});
		write_reg(fhlp_pkg::CFG_SUFFIX_BYTES, {8'($urandom), c.suffix_bytes});
		write_reg(fhlp_pkg::CFG_BIG_ENDIAN, {15'($urandom), c.big_endian});
		write_reg(fhlp_pkg::CFG_SEQ_OFFSET, {6'($urandom), c.seq_offset});
		write_reg(fhlp_pkg::CFG_SEQ_LENGTH, {13'($urandom), c.seq_length});
		if ($urandom_range(0, 3) == 0)
			write_reg(fhlp_pkg::CFG_INDEX_W'($urandom_range(6, 7)), 16'($urandom));
		cfg_valid <= 1'b0;
	endtask

	function automatic fhlp_pkg::cfg_t make_cfg(int unsigned pre, int unsigned sz,
			int unsigned suf, bit be, int unsigned off, int unsigned len);
		fhlp_pkg::cfg_t c;
		c.prefix_bytes = 8'(pre);
		c.size_bytes = 4'(sz);
		c.suffix_bytes = 8'(suf);
		c.big_endian = be;
		c.seq_offset = 10'(off);
		c.seq_length = 3'(len);
		return c;
	endfunction

	// Mostly short headers. The sequence field usually lands inside or just
	// past the header, and now and then anywhere in the 10-bit range.
	function automatic fhlp_pkg::cfg_t random_small_cfg();
		fhlp_pkg::cfg_t c;
		c.prefix_bytes = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(5, 40)) :
			8'($urandom_range(0, 4));
		c.size_bytes = 4'($urandom);
		c.suffix_bytes = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(5, 40)) :
			8'($urandom_range(0, 4));
		c.big_endian = 1'($urandom);
		c.seq_length = 3'($urandom);
		if ($urandom_range(0, 5) == 0)
			c.seq_offset = 10'($urandom);
		else
			c.seq_offset = 10'($urandom_range(0, c.prefix_bytes + c.suffix_bytes + 9));
		return c;
	endfunction

	// One phase of traffic under the current registers: mostly whole headers,
	// with truncated headers cut short by a restart and stray restarts mixed in.
	// Sometimes the phase ends part way into a header, so that the next set of
	// register values takes effect mid-header.
	task automatic run_phase(input int unsigned target);
		int unsigned hdr_len;
		int unsigned start_count;
		int unsigned pick;
		hdr_len = sb.header_length();
		start_count = items_sent;
		while (items_sent - start_count < target) begin
			pick = $urandom_range(0, 19);
			if (pick == 0) begin
				send_restart();
			end else if (pick == 1 && hdr_len > 1) begin
				send_random_bytes($urandom_range(1, hdr_len - 1));
				send_restart();
			end else begin
				send_random_bytes(hdr_len);
			end
		end
		if ($urandom_range(0, 2) == 0 && hdr_len > 1)
			send_random_bytes($urandom_range(1, hdr_len - 1));
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Registers at their reset values: a four-byte big-endian size with no
		// sequence field, then a header abandoned after one byte.
		send_byte(8'hFF);
		send_byte(8'h00);
		send_byte(8'h80);
		send_byte(8'h01);
		send_byte(8'h5A);
		send_restart();

		// A size width of zero acts as one byte, and an oversized sequence width
		// as four bytes, which here fills the header exactly. Little-endian.
		apply_config(make_cfg(2, 0, 1, 1'b0, 0, 7));
		send_byte(8'hFF);
		send_byte(8'h12);
		send_byte(8'h34);
		send_byte(8'h56);

		// An oversized size width acts as eight bytes; the sequence field runs
		// one byte past the end of the header, so it must be flagged invalid.
		apply_config(make_cfg(0, 15, 0, 1'b1, 5, 4));
		send_byte(8'hFF);
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(8'h00);
		send_byte(8'h81);
		send_byte(8'h7E);
		send_byte(8'hC3);
		send_byte(8'h3C);

		// One-byte headers, every byte closes one; an empty sequence field that
		// sits right at the header end still counts as valid.
		apply_config(make_cfg(0, 1, 0, 1'b1, 1, 0));
		send_byte(8'h00);
		send_byte(8'hFF);

		// Longest header of all, with the sequence field ending on its last byte.
		apply_config(make_cfg(255, 15, 255, 1'b1, 514, 4));
		send_random_bytes(518);

		// Long suffix, little-endian, sequence field at the far end of the range.
		apply_config(make_cfg(0, 8, 255, 1'b0, 1023, 7));
		run_phase(263);

		while (items_sent < ITEM_TARGET) begin
			apply_config(random_small_cfg());
			run_phase($urandom_range(40, 120));
		end

		stop_sending();
		wait_idle();
		if (sb.errors == 0)
			$display("fixed_header_length_parser_unit test passed");
		else
			$display("fixed_header_length_parser_unit test failed");
		$finish;
	end

endmodule
